// ===== rtl/core/jls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jls_pkg: shared constants and types for the jacobi linear solver
// Holds register addresses, request codes and default parameter values.
// ----------------------------------------------------------------------------
package jls_pkg;

    localparam int NMaxDefault      = 16;
    localparam int FracBitsDefault  = 16;

    localparam logic [4:0]  OrderReset   = 5'd16;
    localparam logic [15:0] MaxIterReset = 16'd1000;
    localparam logic [30:0] TolReset     = 31'd1;

    // request codes
    typedef enum logic [1:0] {
        REQ_LOAD_COEF = 2'd0,
        REQ_LOAD_RHS  = 2'd1,
        REQ_START     = 2'd2,
        REQ_NONE      = 2'd3
    } req_t;

    // register addresses
    localparam logic [3:0] AddrOrder   = 4'd0;
    localparam logic [3:0] AddrMaxIter = 4'd4;
    localparam logic [3:0] AddrTol     = 4'd8;

    typedef struct packed {
        logic [3:0]  index;
        logic [31:0] solution;
        logic [15:0] iterations_used;
        logic        converged;
        logic        divide_error;
        logic        last;
    } res_t;

endpackage

// ===== rtl/core/jls_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jls_req_if / jls_res_if: valid/ready channels of the solver
// Request channel carries load and start transactions, result channel carries
// solution elements.
// ----------------------------------------------------------------------------
interface jls_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [3:0]  row;
    logic [3:0]  col;
    logic signed [31:0] value;
    modport source (output valid, req_type, row, col, value, input ready);
    modport sink   (input valid, req_type, row, col, value, output ready);
endinterface

interface jls_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic signed [31:0] solution;
    logic [15:0] iterations_used;
    logic        converged;
    logic        divide_error;
    logic        last;
    modport source (output valid, index, solution, iterations_used, converged,
                    divide_error, last, input ready);
    modport sink   (input valid, index, solution, iterations_used, converged,
                    divide_error, last, output ready);
endinterface

// ===== rtl/core/jacobi_linear_solver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacobi_linear_solver: fixed-point Jacobi solver with a shared datapath
// Load transactions write the stores directly. A start transaction runs Jacobi
// sweeps on one multiplier, one serial divider and one serial square root unit.
// ----------------------------------------------------------------------------
// Loads: one transaction per cycle, no result. Start: busy for S sweeps of
//   order n (per row a multiply-accumulate over the columns and a divide,
//   then two norm passes), then n results, one per cycle while res.ready is
//   high; no request is taken until the last result.
// Reset: rst_n asynchronous, clears control and the configuration to defaults;
//   matrix and rhs stores are undefined until written.
module jacobi_linear_solver
    import jls_pkg::*;
#(
    parameter int N_MAX     = NMaxDefault,
    parameter int FRAC_BITS = FracBitsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    jls_req_if.sink     req,
    jls_res_if.source   res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW  = $clog2(N_MAX);
    localparam int AW  = $clog2(N_MAX*N_MAX);
    localparam int CAP = (N_MAX < 16) ? N_MAX : 16;
    localparam int DW  = 96;   // divider numerator width

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_MRD   = 12'b000000000010,
        S_MAC   = 12'b000000000100,
        S_DIVST = 12'b000000001000,
        S_DIV   = 12'b000000010000,
        S_DIVWB = 12'b000000100000,
        S_SQ    = 12'b000001000000,
        S_SQRT  = 12'b000010000000,
        S_CMP   = 12'b000100000000,
        S_OUT   = 12'b001000000000,
        S_SQMUL = 12'b010000000000,
        S_MWAIT = 12'b100000000000
    } state_t;

    // configuration
    logic [4:0]  order_reg;
    logic [15:0] max_iter_reg;
    logic [30:0] tol_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg    <= OrderReset;
            max_iter_reg <= MaxIterReset;
            tol_reg      <= TolReset;
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                AddrOrder:   order_reg    <= pwdata[4:0];
                AddrMaxIter: max_iter_reg <= pwdata[15:0];
                AddrTol:     tol_reg      <= pwdata[30:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            AddrOrder:   prdata = {27'd0, order_reg};
            AddrMaxIter: prdata = {16'd0, max_iter_reg};
            AddrTol:     prdata = {1'b0, tol_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // stores
    logic signed [31:0] coef_mem [N_MAX*N_MAX];
    logic signed [31:0] rhs_mem  [N_MAX];
    logic signed [31:0] xc_mem   [N_MAX];
    logic signed [31:0] xn_mem   [N_MAX];

    state_t state_reg, state_next;
    logic [IW:0] n_reg;
    logic [IW:0] i_reg, j_reg;
    logic [15:0] sweep_reg;
    logic        conv_reg, err_reg, use_next_reg, pass_reg;
    logic signed [31:0] a_rd_reg, x_rd_reg, rhs_rd_reg, diag_reg;
    logic signed [63:0] prod_reg;
    logic signed [55:0] acc_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [63:0]   den_reg;
    logic          neg_reg;
    logic [6:0]    cnt_reg;
    logic [81:0]   sq_reg;
    logic [63:0]   norm_a_reg, norm_b_reg;
    logic [40:0]   root_reg;
    logic [63:0]   sqrt_rem_reg;
    logic [IW:0]   out_i_reg;
    logic          out_valid_reg;
    res_t          out_reg;

    logic req_fire, res_fire;
    assign req_fire  = req.valid && req.ready;
    assign res_fire  = res.valid && res.ready;
    assign req.ready = (state_reg == S_IDLE);

    // order clamp
    logic [IW:0] n_eff;
    always_comb
    begin
        if (order_reg == 5'd0)
            n_eff = (IW+1)'(1);
        else if (32'(order_reg) > CAP)
            n_eff = (IW+1)'(CAP);
        else
            n_eff = (IW+1)'(order_reg);
    end

    // coefficient addresses
    logic [AW-1:0] coef_wr_addr, coef_rd_addr;
    assign coef_wr_addr = AW'(32'(req.row) * N_MAX + 32'(req.col));
    assign coef_rd_addr = AW'(32'(i_reg) * N_MAX + 32'(j_reg));

    // load path
    always_ff @(posedge clk)
    begin
        if (req_fire && req.req_type == REQ_LOAD_COEF
            && 32'(req.row) < N_MAX && 32'(req.col) < N_MAX)
            coef_mem[coef_wr_addr] <= req.value;
        if (req_fire && req.req_type == REQ_LOAD_RHS && 32'(req.row) < N_MAX)
            rhs_mem[IW'(req.row)] <= req.value;
    end

    // shared datapath signals
    logic signed [63:0] sh_prod;
    logic signed [55:0] num_s;
    logic [63:0] num_mag;
    logic [DW-1:0] trial;
    logic [40:0] root_c;
    logic [63:0] sqrt_shift, sqrt_trial;
    logic        sqrt_ge;
    logic [63:0] ndiff;
    logic [63:0] sat_mag;
    logic signed [31:0] q_final;
    logic signed [31:0] vsel;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_out;

    assign sh_prod = prod_reg >>> FRAC_BITS;
    assign num_s   = 56'(rhs_rd_reg) - acc_reg;
    assign num_mag = num_s[55] ? 64'(-num_s) : 64'(num_s);
    assign trial   = {rem_reg[DW-2:0], quo_reg[DW-1]};
    assign ndiff   = (norm_a_reg > norm_b_reg) ? norm_a_reg - norm_b_reg
                                               : norm_b_reg - norm_a_reg;
    assign vsel    = use_next_reg ? xn_mem[IW'(j_reg)] : xc_mem[IW'(j_reg)];

    // one multiplier for products and squares
    assign mul_a   = (state_reg == S_SQMUL) ? vsel : a_rd_reg;
    assign mul_b   = (state_reg == S_SQMUL) ? vsel : x_rd_reg;
    assign mul_out = 64'(mul_a) * 64'(mul_b);

    // digit-by-digit square root step, two radicand bits per cycle
    assign sqrt_shift = {sqrt_rem_reg[61:0], sq_reg[{cnt_reg[5:0], 1'b0} +: 2]};
    assign sqrt_trial = {21'd0, root_reg, 2'b01};
    assign sqrt_ge    = (sqrt_shift >= sqrt_trial);
    assign root_c     = {root_reg[39:0], sqrt_ge};

    always_comb
    begin
        if (quo_reg[DW-1:32] != '0)
            sat_mag = 64'hFFFF_FFFF_FFFF_FFFF;
        else
            sat_mag = 64'(quo_reg[31:0]);
        if (neg_reg)
            q_final = (sat_mag > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-sat_mag);
        else
            q_final = (sat_mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(sat_mag);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (req_fire && req.req_type == REQ_START)
                         state_next = (max_iter_reg == 16'd0) ? S_OUT : S_MRD;
            S_MRD:   state_next = S_MWAIT;
            S_MWAIT: state_next = S_MAC;
            S_MAC:   state_next = (j_reg == n_reg - 1'b1) ? S_DIVST : S_MRD;
            S_DIVST: state_next = S_DIV;
            S_DIV:   state_next = (cnt_reg == 7'd0) ? S_DIVWB : S_DIV;
            S_DIVWB: state_next = (i_reg == n_reg - 1'b1) ? S_SQMUL : S_MRD;
            S_SQMUL: state_next = S_SQ;
            S_SQ:    state_next = (j_reg == n_reg - 1'b1) ? S_SQRT : S_SQMUL;
            S_SQRT:  state_next = (cnt_reg == 7'd0)
                                  ? (pass_reg ? S_CMP : S_SQMUL) : S_SQRT;
            S_CMP:   state_next = S_IDLE;
            S_OUT:   state_next = S_OUT;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_CMP)
        begin
            if ((ndiff < 64'(tol_reg)) || (sweep_reg + 16'd1 >= max_iter_reg))
                state_next = S_OUT;
            else
                state_next = S_MRD;
        end
        if (state_reg == S_OUT && res_fire && out_reg.last)
            state_next = S_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                n_reg        <= n_eff;
                i_reg        <= '0;
                j_reg        <= '0;
                acc_reg      <= '0;
                sweep_reg    <= '0;
                conv_reg     <= 1'b0;
                err_reg      <= 1'b0;
                out_i_reg    <= '0;
                pass_reg     <= 1'b0;
                use_next_reg <= 1'b0;
                if (req_fire && req.req_type == REQ_START)
                    for (int k = 0; k < N_MAX; k++)
                        xc_mem[k] <= '0;
            end
            S_MRD:
            begin
                a_rd_reg   <= coef_mem[coef_rd_addr];
                x_rd_reg   <= xc_mem[IW'(j_reg)];
                rhs_rd_reg <= rhs_mem[IW'(i_reg)];
            end
            S_MWAIT:
                prod_reg <= mul_out;
            S_MAC:
            begin
                if (j_reg == i_reg)
                    diag_reg <= a_rd_reg;
                else
                    acc_reg <= acc_reg + 56'(sh_prod);
                j_reg <= (j_reg == n_reg - 1'b1) ? '0 : j_reg + 1'b1;
            end
            S_DIVST:
            begin
                neg_reg <= num_s[55] ^ diag_reg[31];
                den_reg <= diag_reg[31] ? 64'(-64'(diag_reg)) : 64'(diag_reg);
                quo_reg <= DW'(num_mag) << FRAC_BITS;
                rem_reg <= '0;
                cnt_reg <= 7'(DW - 1);
                if (diag_reg == 0)
                    err_reg <= 1'b1;
            end
            S_DIV:
            begin
                if (trial >= DW'(den_reg))
                begin
                    rem_reg <= trial - DW'(den_reg);
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
            end
            S_DIVWB:
            begin
                if (den_reg == 0)
                    xn_mem[IW'(i_reg)] <= num_s[55] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                else
                    xn_mem[IW'(i_reg)] <= q_final;
                acc_reg <= '0;
                i_reg   <= (i_reg == n_reg - 1'b1) ? '0 : i_reg + 1'b1;
                sq_reg  <= '0;
                use_next_reg <= 1'b1;
                pass_reg <= 1'b0;
            end
            S_SQMUL:
                prod_reg <= mul_out;
            S_SQ:
            begin
                sq_reg <= sq_reg + 82'(unsigned'(prod_reg));
                if (j_reg == n_reg - 1'b1)
                begin
                    j_reg        <= '0;
                    cnt_reg      <= 7'd40;
                    root_reg     <= '0;
                    sqrt_rem_reg <= '0;
                end
                else
                    j_reg <= j_reg + 1'b1;
            end
            S_SQRT:
            begin
                root_reg <= root_c;
                if (sqrt_ge)
                    sqrt_rem_reg <= sqrt_shift - sqrt_trial;
                else
                    sqrt_rem_reg <= sqrt_shift;
                if (cnt_reg == 7'd0)
                begin
                    if (pass_reg) norm_b_reg <= 64'(root_c);
                    else          norm_a_reg <= 64'(root_c);
                    pass_reg     <= 1'b1;
                    use_next_reg <= 1'b0;
                    sq_reg       <= '0;
                end
                else
                    cnt_reg <= cnt_reg - 7'd1;
            end
            S_CMP:
            begin
                sweep_reg <= sweep_reg + 16'd1;
                if (ndiff < 64'(tol_reg))
                    conv_reg <= 1'b1;
                else
                    for (int k = 0; k < N_MAX; k++)
                        if (sweep_reg + 16'd1 < max_iter_reg)
                            xc_mem[k] <= xn_mem[k];
                acc_reg <= '0;
            end
            S_OUT:
                if (res_fire || !out_valid_reg)
                    out_i_reg <= out_i_reg + 1'b1;
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_OUT && (res_fire || !out_valid_reg))
            out_valid_reg <= (out_i_reg < n_reg) && !(res_fire && out_reg.last);
        else if (res_fire)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (res_fire || !out_valid_reg))
        begin
            out_reg.index           <= 4'(out_i_reg);
            out_reg.solution        <= conv_reg ? xn_mem[IW'(out_i_reg)]
                                                : xc_mem[IW'(out_i_reg)];
            out_reg.iterations_used <= sweep_reg;
            out_reg.converged       <= conv_reg;
            out_reg.divide_error    <= err_reg;
            out_reg.last            <= (out_i_reg == n_reg - 1'b1);
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.index           = out_reg.index;
    assign res.solution        = out_reg.solution;
    assign res.iterations_used = out_reg.iterations_used;
    assign res.converged       = out_reg.converged;
    assign res.divide_error    = out_reg.divide_error;
    assign res.last            = out_reg.last;

    // checks
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !req.ready) else $error("ready while busy");
    a_res_only_out: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> state_reg == S_OUT || state_reg == S_IDLE)
        else $error("result outside output phase");
    a_sweep_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |-> sweep_reg <= max_iter_reg)
        else $error("sweep count beyond limit");

endmodule
